// ===== rtl/core/cprd_pkg.sv =====
// constants, widths and state type shared by the coherent pulse run detector
`default_nettype none

package cprd_pkg;

   localparam int CLASSES   = 3;
   localparam int ENTRIES   = 2 * CLASSES;
   localparam int ENT_W     = $clog2(ENTRIES);

   localparam int DUR_IN_W  = 24;
   localparam int AVG_W     = 16;
   localparam int CNT_W     = 10;
   localparam int IDX_W     = 16;
   localparam int PROD_W    = AVG_W + CNT_W;
   localparam int DVD_W     = PROD_W + 1;
   localparam int DVS_W     = CNT_W + 1;
   localparam int MATCH_W   = AVG_W + 4;
   localparam int STEP_W    = $clog2(DVD_W);

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] REG_MIN_DURATION = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_MAX_DURATION = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_MAX_RUN      = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_MIN_RUN      = 2'd3;

   localparam logic [AVG_W-1:0] MIN_DURATION_RST = 16'd40;
   localparam logic [AVG_W-1:0] MAX_DURATION_RST = 16'd4000;
   localparam logic [CNT_W-1:0] MAX_RUN_RST      = 10'd500;
   localparam logic [CNT_W-1:0] MIN_RUN_RST      = 10'd13;

   localparam logic [CNT_W-1:0]   CNT_MAX        = 10'd1023;
   localparam logic [CNT_W-1:0]   MIN_FULL_COUNT = 10'd3;
   localparam logic [MATCH_W-1:0] TOL_DIV        = 20'd10;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_WIN,
      ST_MATCH,
      ST_MUL,
      ST_ADD,
      ST_DIV,
      ST_WRITE,
      ST_JOINED,
      ST_SCAN,
      ST_CLOSE,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/coherent_pulse_run_detector.sv =====
// coherent pulse run detector: class matching, serial averaging and run reporting
`default_nettype none

// One request carries one pulse and gives exactly one response. A pulse that joins an
// existing duration class is tried against one class per cycle, then passes through a
// bit-serial multiply of the class average by its count and a restoring divide for the
// new average. Closing a run adds a one-entry-per-cycle scan for the shortest class
// average.
// A new request is taken once the previous one has finished; its response may still be
// waiting in the output register.
module coherent_pulse_run_detector (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // duration [23:0], clear_best [24], zero [31:25]
   input  wire  [cprd_pkg::REQ_DATA_W-1:0]      req_tdata,
   // level
   input  wire                                  req_tuser,
   // end_of_capture
   input  wire                                  req_tlast,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // accepted [0], run_length [10:1], run_start [26:11], shortest_pulse [42:27],
   // new_best [43], zero [47:44]
   output logic [cprd_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // run_done
   output logic                                 rsp_tlast,
   input  wire                                  csr_we,
   input  wire  [cprd_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  wire  [cprd_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   import cprd_pkg::*;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;

   logic [AVG_W-1:0] min_dur_ff, min_dur_in;
   logic [AVG_W-1:0] max_dur_ff, max_dur_in;
   logic [CNT_W-1:0] max_run_ff, max_run_in;
   logic [CNT_W-1:0] min_run_ff, min_run_in;

   logic [AVG_W-1:0] avg_ff [ENTRIES];
   logic [AVG_W-1:0] avg_in [ENTRIES];
   logic [CNT_W-1:0] cnt_ff [ENTRIES];
   logic [CNT_W-1:0] cnt_in [ENTRIES];

   logic [CNT_W-1:0] run_len_ff, run_len_in;
   logic [IDX_W-1:0] run_start_ff, run_start_in;
   logic [IDX_W-1:0] pidx_ff, pidx_in;
   logic [CNT_W-1:0] best_ff, best_in;

   logic                closed_ff, closed_in;
   logic                lvl_ff, lvl_in;
   logic                eoc_ff, eoc_in;
   logic [DUR_IN_W-1:0] dur_ff, dur_in;
   logic [ENT_W-1:0]    idx_ff, idx_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [AVG_W-1:0]    wavg_ff, wavg_in;
   logic [CNT_W-1:0]    wcnt_ff, wcnt_in;
   logic [CNT_W-1:0]    mq_ff, mq_in;
   logic [DVD_W-1:0]    acc_ff, acc_in;
   logic [DVS_W-1:0]    rem_ff, rem_in;
   logic [AVG_W-1:0]    scan_min_ff, scan_min_in;

   logic             res_acc_ff, res_acc_in;
   logic             res_done_ff, res_done_in;
   logic [CNT_W-1:0] res_len_ff, res_len_in;
   logic [IDX_W-1:0] res_start_ff, res_start_in;
   logic [AVG_W-1:0] res_short_ff, res_short_in;
   logic             res_best_ff, res_best_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_acc_ff, rsp_acc_in;
   logic             rsp_done_ff, rsp_done_in;
   logic [CNT_W-1:0] rsp_len_ff, rsp_len_in;
   logic [IDX_W-1:0] rsp_start_ff, rsp_start_in;
   logic [AVG_W-1:0] rsp_short_ff, rsp_short_in;
   logic             rsp_best_ff, rsp_best_in;

   logic [AVG_W-1:0]   rd_avg;
   logic [CNT_W-1:0]   rd_cnt;
   logic [AVG_W-1:0]   dur16;
   logic [AVG_W-1:0]   diff;
   logic [AVG_W:0]     diff_inc;
   logic [MATCH_W-1:0] tol;
   logic               is_match;
   logic [CNT_W-1:0]   limit;
   logic               in_window;
   logic [DVS_W-1:0]   divisor;
   logic [DVS_W:0]     rem_try;
   logic               rem_ge;
   logic [DVS_W:0]     rem_sub;
   logic [CNT_W:0]     new_len;
   logic               new_best;
   logic               scan_take;
   logic               out_free;

   assign rd_avg    = avg_ff[idx_ff];
   assign rd_cnt    = cnt_ff[idx_ff];
   assign dur16     = dur_ff[AVG_W-1:0];
   assign diff      = (dur16 > rd_avg) ? (dur16 - rd_avg) : (rd_avg - dur16);
   assign diff_inc  = {1'b0, diff} + (AVG_W+1)'(1);
   assign tol       = MATCH_W'(diff_inc) * TOL_DIV;
   assign is_match  = tol <= MATCH_W'(rd_avg);
   assign limit     = (max_run_ff == '0) ? CNT_W'(1) : max_run_ff;
   assign in_window = (dur_ff >= DUR_IN_W'(min_dur_ff)) && (dur_ff <= DUR_IN_W'(max_dur_ff));
   assign divisor   = {1'b0, wcnt_ff} + DVS_W'(1);
   assign rem_try   = {rem_ff, acc_ff[DVD_W-1]};
   assign rem_ge    = rem_try >= {1'b0, divisor};
   assign rem_sub   = rem_try - {1'b0, divisor};
   assign new_len   = {1'b0, run_len_ff} + (CNT_W+1)'(1);
   assign new_best  = (run_len_ff > min_run_ff) && (run_len_ff > best_ff);
   assign scan_take = (rd_avg != '0) && (rd_cnt >= MIN_FULL_COUNT)
                      && ((scan_min_ff == '0) || (rd_avg < scan_min_ff));
   assign out_free  = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_done_ff;
   assign rsp_tdata  = {4'b0, rsp_best_ff, rsp_short_ff, rsp_start_ff, rsp_len_ff, rsp_acc_ff};

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      min_dur_in   = min_dur_ff;
      max_dur_in   = max_dur_ff;
      max_run_in   = max_run_ff;
      min_run_in   = min_run_ff;
      avg_in       = avg_ff;
      cnt_in       = cnt_ff;
      run_len_in   = run_len_ff;
      run_start_in = run_start_ff;
      pidx_in      = pidx_ff;
      best_in      = best_ff;
      closed_in    = closed_ff;
      lvl_in       = lvl_ff;
      eoc_in       = eoc_ff;
      dur_in       = dur_ff;
      idx_in       = idx_ff;
      step_in      = step_ff;
      wavg_in      = wavg_ff;
      wcnt_in      = wcnt_ff;
      mq_in        = mq_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      scan_min_in  = scan_min_ff;
      res_acc_in   = res_acc_ff;
      res_done_in  = res_done_ff;
      res_len_in   = res_len_ff;
      res_start_in = res_start_ff;
      res_short_in = res_short_ff;
      res_best_in  = res_best_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_start_in = rsp_start_ff;
      rsp_short_in = rsp_short_ff;
      rsp_best_in  = rsp_best_ff;

      if (csr_we) begin
         unique case (csr_addr)
            REG_MIN_DURATION: min_dur_in = csr_wdata[AVG_W-1:0];
            REG_MAX_DURATION: max_dur_in = csr_wdata[AVG_W-1:0];
            REG_MAX_RUN:      max_run_in = csr_wdata[CNT_W-1:0];
            REG_MIN_RUN:      min_run_in = csr_wdata[CNT_W-1:0];
            default:          ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               lvl_in       = req_tuser;
               eoc_in       = req_tlast;
               dur_in       = req_tdata[DUR_IN_W-1:0];
               closed_in    = 1'b0;
               res_acc_in   = 1'b0;
               res_done_in  = 1'b0;
               res_len_in   = '0;
               res_start_in = '0;
               res_short_in = '0;
               res_best_in  = 1'b0;
               if (req_tdata[DUR_IN_W]) begin
                  best_in = '0;
               end
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (eoc_ff) begin
               if (run_len_ff != '0) begin
                  ret_in      = ST_OUT;
                  idx_in      = '0;
                  scan_min_in = '0;
                  state_in    = ST_SCAN;
               end else begin
                  state_in = ST_OUT;
               end
            end else if ((run_len_ff != '0) && (run_len_ff >= limit)) begin
               closed_in   = 1'b1;
               ret_in      = ST_WIN;
               idx_in      = '0;
               scan_min_in = '0;
               state_in    = ST_SCAN;
            end else begin
               state_in = ST_WIN;
            end
         end
         ST_WIN: begin
            if (!in_window) begin
               if (run_len_ff != '0) begin
                  ret_in      = ST_OUT;
                  idx_in      = '0;
                  scan_min_in = '0;
                  state_in    = ST_SCAN;
               end else begin
                  state_in = ST_OUT;
               end
            end else begin
               idx_in   = ENT_W'(lvl_ff);
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            if (rd_cnt == '0) begin
               avg_in[idx_ff] = dur16;
               cnt_in[idx_ff] = CNT_W'(1);
               state_in       = ST_JOINED;
            end else if (is_match) begin
               wavg_in  = rd_avg;
               wcnt_in  = rd_cnt;
               mq_in    = rd_cnt;
               acc_in   = '0;
               step_in  = '0;
               state_in = ST_MUL;
            end else if (int'(idx_ff) >= ENTRIES - 2) begin
               // no class fits: close the run, then start a new one with this pulse
               closed_in   = 1'b1;
               ret_in      = ST_MATCH;
               idx_in      = '0;
               scan_min_in = '0;
               state_in    = ST_SCAN;
            end else begin
               idx_in = idx_ff + ENT_W'(2);
            end
         end
         ST_MUL: begin
            acc_in  = (acc_ff << 1) + (mq_ff[CNT_W-1] ? DVD_W'(wavg_ff) : '0);
            mq_in   = mq_ff << 1;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(CNT_W - 1)) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            acc_in   = acc_ff + DVD_W'(dur16);
            rem_in   = '0;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = rem_ge ? rem_sub[DVS_W-1:0] : rem_try[DVS_W-1:0];
            acc_in  = {acc_ff[DVD_W-2:0], rem_ge};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DVD_W - 1)) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            avg_in[idx_ff] = acc_ff[AVG_W-1:0];
            cnt_in[idx_ff] = (wcnt_ff == CNT_MAX) ? wcnt_ff : wcnt_ff + CNT_W'(1);
            state_in       = ST_JOINED;
         end
         ST_JOINED: begin
            if (run_len_ff == '0) begin
               run_start_in = pidx_ff;
            end
            run_len_in = new_len[CNT_W-1:0];
            res_acc_in = 1'b1;
            if (!closed_ff && (new_len >= {1'b0, limit})) begin
               ret_in      = ST_OUT;
               idx_in      = '0;
               scan_min_in = '0;
               state_in    = ST_SCAN;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_SCAN: begin
            if (scan_take) begin
               scan_min_in = rd_avg;
            end
            if (int'(idx_ff) == ENTRIES - 1) begin
               state_in = ST_CLOSE;
            end else begin
               idx_in = idx_ff + ENT_W'(1);
            end
         end
         ST_CLOSE: begin
            res_done_in  = 1'b1;
            res_len_in   = run_len_ff;
            res_start_in = run_start_ff;
            res_short_in = scan_min_ff;
            res_best_in  = new_best;
            if (new_best) begin
               best_in = run_len_ff;
            end
            for (int e = 0; e < ENTRIES; e++) begin
               avg_in[e] = '0;
               cnt_in[e] = '0;
            end
            run_len_in = '0;
            idx_in     = ENT_W'(lvl_ff);
            state_in   = ret_ff;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = res_acc_ff;
               rsp_done_in  = res_done_ff;
               rsp_len_in   = res_len_ff;
               rsp_start_in = res_start_ff;
               rsp_short_in = res_short_ff;
               rsp_best_in  = res_best_ff;
               if (!eoc_ff) begin
                  pidx_in = pidx_ff + IDX_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_OUT;
         min_dur_ff   <= MIN_DURATION_RST;
         max_dur_ff   <= MAX_DURATION_RST;
         max_run_ff   <= MAX_RUN_RST;
         min_run_ff   <= MIN_RUN_RST;
         avg_ff       <= '{default: '0};
         cnt_ff       <= '{default: '0};
         run_len_ff   <= '0;
         run_start_ff <= '0;
         pidx_ff      <= '0;
         best_ff      <= '0;
         closed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         min_dur_ff   <= min_dur_in;
         max_dur_ff   <= max_dur_in;
         max_run_ff   <= max_run_in;
         min_run_ff   <= min_run_in;
         avg_ff       <= avg_in;
         cnt_ff       <= cnt_in;
         run_len_ff   <= run_len_in;
         run_start_ff <= run_start_in;
         pidx_ff      <= pidx_in;
         best_ff      <= best_in;
         closed_ff    <= closed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff       <= lvl_in;
      eoc_ff       <= eoc_in;
      dur_ff       <= dur_in;
      idx_ff       <= idx_in;
      step_ff      <= step_in;
      wavg_ff      <= wavg_in;
      wcnt_ff      <= wcnt_in;
      mq_ff        <= mq_in;
      acc_ff       <= acc_in;
      rem_ff       <= rem_in;
      scan_min_ff  <= scan_min_in;
      res_acc_ff   <= res_acc_in;
      res_done_ff  <= res_done_in;
      res_len_ff   <= res_len_in;
      res_start_ff <= res_start_in;
      res_short_ff <= res_short_in;
      res_best_ff  <= res_best_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_start_ff <= rsp_start_in;
      rsp_short_ff <= rsp_short_in;
      rsp_best_ff  <= rsp_best_in;
   end

   // a response is only ever loaded from the output state
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("response loaded outside output state");

   // a closed run is never empty
   a_done_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> (rsp_len_ff != '0))
      else $error("closed run reported with zero length");

   // averaging only runs on a class that already holds pulses
   a_mul_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (wcnt_ff != '0))
      else $error("average update on an empty class");

endmodule

`default_nettype wire

// ===== verif/cprd_run_checker.sv =====
// checker for the pulse run detector: tracks config writes, predicts each response, compares
module cprd_run_checker
   import cprd_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   input  wire                    req_tready,
   input  wire [REQ_DATA_W-1:0]   req_tdata,
   input  wire                    req_tuser,
   input  wire                    req_tlast,
   input  wire                    rsp_tvalid,
   input  wire                    rsp_tready,
   input  wire [RSP_DATA_W-1:0]   rsp_tdata,
   input  wire                    rsp_tlast,
   input  wire                    csr_we,
   input  wire [CSR_ADDR_W-1:0]   csr_addr,
   input  wire [CSR_DATA_W-1:0]   csr_wdata,
   output int                     pending,
   output int                     errors
);

   typedef struct packed {
      logic             accepted;
      logic             run_done;
      logic [CNT_W-1:0] run_length;
      logic [IDX_W-1:0] run_start;
      logic [AVG_W-1:0] shortest;
      logic             new_best;
   } pulse_result_t;

   logic [AVG_W-1:0] class_avg [ENTRIES];
   logic [CNT_W-1:0] class_cnt [ENTRIES];
   logic [CNT_W-1:0] run_len;
   logic [IDX_W-1:0] run_first;
   logic [IDX_W-1:0] pulse_idx;
   logic [CNT_W-1:0] best_len;
   logic [AVG_W-1:0] min_dur;
   logic [AVG_W-1:0] max_dur;
   logic [CNT_W-1:0] max_run;
   logic [CNT_W-1:0] min_run;

   pulse_result_t pending_results [$];
   int            rsp_count;

   initial begin
      pending = 0;
      errors = 0;
      rsp_count = 0;
   end

   // report the closed run and empty the classes
   function automatic pulse_result_t close_run();
      pulse_result_t    res;
      logic [AVG_W-1:0] low;
      res = '0;
      low = '0;
      for (int e = 0; e < ENTRIES; e++)
         if (class_avg[e] != 0 && class_cnt[e] >= MIN_FULL_COUNT &&
             (low == 0 || class_avg[e] < low))
            low = class_avg[e];
      res.run_done = 1'b1;
      res.run_length = run_len;
      res.run_start = run_first;
      res.shortest = low;
      if (run_len > min_run && run_len > best_len) begin
         res.new_best = 1'b1;
         best_len = run_len;
      end
      for (int e = 0; e < ENTRIES; e++) begin
         class_avg[e] = '0;
         class_cnt[e] = '0;
      end
      run_len = '0;
      return res;
   endfunction

   function automatic logic join_class(input logic lvl, input logic [AVG_W-1:0] dur);
      int          e;
      int unsigned avg, cnt, diff;
      for (int k = 0; k < CLASSES; k++) begin
         e = 2 * k + lvl;
         avg = class_avg[e];
         cnt = class_cnt[e];
         if (cnt == 0) begin
            class_avg[e] = dur;
            class_cnt[e] = CNT_W'(1);
            return 1'b1;
         end
         diff = (dur > avg) ? dur - avg : avg - dur;
         if (diff < avg / TOL_DIV) begin
            class_avg[e] = AVG_W'((avg * cnt + dur) / (cnt + 1));
            if (cnt < CNT_MAX) class_cnt[e] = CNT_W'(cnt + 1);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic pulse_result_t predict_pulse_result(input logic lvl,
         input logic [DUR_IN_W-1:0] dur, input logic eoc, input logic clr);
      pulse_result_t    res;
      logic [CNT_W-1:0] lim;
      logic             closed;
      res = '0;
      closed = 1'b0;
      lim = (max_run == 0) ? CNT_W'(1) : max_run;
      if (clr) best_len = '0;
      if (eoc) begin
         if (run_len != 0) res = close_run();
         return res;
      end
      // run left full by the previous request, or by a lowered limit
      if (run_len != 0 && run_len >= lim) begin
         res = close_run();
         closed = 1'b1;
      end
      if (dur < min_dur || dur > max_dur) begin
         if (run_len != 0) res = close_run();
      end else begin
         if (!join_class(lvl, dur[AVG_W-1:0])) begin
            res = close_run();
            closed = 1'b1;
            void'(join_class(lvl, dur[AVG_W-1:0]));
         end
         if (run_len == 0) run_first = pulse_idx;
         run_len = run_len + 1'b1;
         // a second close in the same request waits for the next one
         if (!closed && run_len >= lim) res = close_run();
         res.accepted = 1'b1;
      end
      pulse_idx = pulse_idx + 1'b1;
      return res;
   endfunction

   task automatic check_field(input string what, input longint unsigned want,
                              input longint unsigned seen);
      if (want != seen) begin
         errors++;
         if (errors <= 10)
            $display("mismatch on %s at response %0d: expected %0d, got %0d",
                     what, rsp_count, want, seen);
      end
   endtask

   always @(posedge clock) begin
      pulse_result_t want;
      int            delta;
      if (reset) begin
         for (int e = 0; e < ENTRIES; e++) begin
            class_avg[e] = '0;
            class_cnt[e] = '0;
         end
         run_len = '0;
         run_first = '0;
         pulse_idx = '0;
         best_len = '0;
         min_dur = MIN_DURATION_RST;
         max_dur = MAX_DURATION_RST;
         max_run = MAX_RUN_RST;
         min_run = MIN_RUN_RST;
         pending_results.delete();
         pending <= 0;
      end else begin
         delta = 0;
         if (csr_we) begin
            case (csr_addr)
               REG_MIN_DURATION: min_dur = csr_wdata[AVG_W-1:0];
               REG_MAX_DURATION: max_dur = csr_wdata[AVG_W-1:0];
               REG_MAX_RUN:      max_run = csr_wdata[CNT_W-1:0];
               REG_MIN_RUN:      min_run = csr_wdata[CNT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            if (pending_results.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("response %0d arrived with no request outstanding", rsp_count);
            end else begin
               want = pending_results.pop_front();
               delta = delta - 1;
               check_field("accepted", want.accepted, rsp_tdata[0]);
               check_field("run_done", want.run_done, rsp_tlast);
               check_field("run_length", want.run_length, rsp_tdata[10:1]);
               check_field("run_start", want.run_start, rsp_tdata[26:11]);
               check_field("shortest_pulse", want.shortest, rsp_tdata[42:27]);
               check_field("new_best", want.new_best, rsp_tdata[43]);
            end
         end
         if (req_tvalid && req_tready) begin
            pending_results.push_back(predict_pulse_result(req_tuser,
               req_tdata[DUR_IN_W-1:0], req_tlast, req_tdata[DUR_IN_W]));
            delta = delta + 1;
         end
         pending <= pending + delta;
      end
   end

endmodule

// ===== verif/coherent_pulse_run_detector_test.sv =====
// testbench top for the pulse run detector: clock, reset, stimulus and verdict
module coherent_pulse_run_detector_test;
   import cprd_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int   pending;
   int   errors;
   int   quiet_cycles = 0;
   int   stall_left = 0;
   logic idle_en = 1'b1;

   always #6 clock = ~clock;

   coherent_pulse_run_detector DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   cprd_run_checker checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .pending(pending), .errors(errors)
   );

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
         stall_left <= pick_gap();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send(input logic lvl, input logic [DUR_IN_W-1:0] dur,
                       input logic eoc, input logic clr);
      int gap;
      gap = idle_en ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_DATA_W-DUR_IN_W-1){1'b0}}, clr, dur};
      req_tuser <= lvl;
      req_tlast <= eoc;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // let every request drain before touching the registers or ending
   task automatic settle(input int extra);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (extra) @(posedge clock);
   endtask

   task automatic set_regs(input logic [15:0] mind, input logic [15:0] maxd,
                           input logic [9:0] mxr, input logic [9:0] mnr);
      csr_we <= 1'b1;
      csr_addr <= REG_MIN_DURATION;
      csr_wdata <= mind;
      @(posedge clock);
      csr_addr <= REG_MAX_DURATION;
      csr_wdata <= maxd;
      @(posedge clock);
      csr_addr <= REG_MAX_RUN;
      csr_wdata <= {6'b0, mxr};
      @(posedge clock);
      csr_addr <= REG_MIN_RUN;
      csr_wdata <= {6'b0, mnr};
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int unsigned dir_dur [14] = '{100, 200, 500, 100, 200, 500, 100,
                                    200, 500, 100, 220, 500, 100, 1000};
      logic        dir_lvl [14] = '{0, 1, 0, 0, 1, 0, 0, 1, 0, 0, 1, 0, 0, 0};
      int unsigned cfg_tab [8][4] = '{
         '{40, 4000, 500, 13},
         '{0, 65535, 1023, 0},
         '{0, 300, 1, 1023},
         '{100, 2000, 0, 0},
         '{65535, 65535, 7, 2},
         '{50, 800, 4, 3},
         '{500, 100, 20, 5},
         '{20, 5000, 30, 10}
      };
      int unsigned base [2][3];
      int unsigned lo_dur, hi_dur, mxr, mnr, dur, jit;
      int          items, kind, k, lvl;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed requests under the reset register values
      send(1'b0, 24'd0, 1'b0, 1'b0);
      send(1'b1, 24'hFFFFFF, 1'b0, 1'b1);
      send(1'b0, 24'd40, 1'b0, 1'b0);
      send(1'b0, 24'd40, 1'b0, 1'b0);
      send(1'b1, 24'd4000, 1'b0, 1'b0);
      send(1'b0, 24'd39, 1'b0, 1'b0);
      // fills all classes of both levels, one tolerance edge included
      foreach (dir_dur[i]) send(dir_lvl[i], DUR_IN_W'(dir_dur[i]), 1'b0, 1'b0);
      send(1'b0, 24'd2000, 1'b0, 1'b0);
      send(1'b1, 24'd300, 1'b1, 1'b0);
      send(1'b0, 24'd300, 1'b1, 1'b1);
      send(1'b1, 24'd4001, 1'b0, 1'b0);

      for (int ph = 0; ph < 9; ph++) begin
         settle(4);
         if (ph < 8) begin
            lo_dur = cfg_tab[ph][0];
            hi_dur = cfg_tab[ph][1];
            mxr = cfg_tab[ph][2];
            mnr = cfg_tab[ph][3];
         end else begin
            lo_dur = $urandom_range(0, 200);
            hi_dur = $urandom_range(300, 65535);
            mxr = $urandom_range(0, 1023);
            mnr = $urandom_range(0, 1023);
         end
         set_regs(AVG_W'(lo_dur), AVG_W'(hi_dur), CNT_W'(mxr), CNT_W'(mnr));
         idle_en <= (ph % 3 != 2);
         items = (lo_dur > hi_dur) ? 40 : 220;
         foreach (base[a, b]) base[a][b] = $urandom_range(lo_dur, hi_dur);
         for (int n = 0; n < items; n++) begin
            kind = $urandom_range(0, 99);
            lvl = $urandom_range(0, 1);
            k = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 2);
            if (kind < 2) begin
               dur = $urandom & 24'hFFFFFF;
               send(1'(lvl), DUR_IN_W'(dur), 1'b1, $urandom_range(0, 9) == 0);
            end else if (kind < 5) begin
               dur = $urandom_range(0, 1) ? ($urandom & 24'hFFFFFF)
                                          : $urandom_range(0, 70000);
               send(1'(lvl), DUR_IN_W'(dur), 1'b0, $urandom_range(0, 49) == 0);
            end else begin
               // new duration for a class slot, which may break the run
               if (kind < 9) base[lvl][k] = $urandom_range(lo_dur, hi_dur);
               jit = base[lvl][k] / 25;
               dur = base[lvl][k] - jit + $urandom_range(0, 2 * jit);
               send(1'(lvl), DUR_IN_W'(dur), 1'b0, $urandom_range(0, 49) == 0);
            end
         end
      end

      settle(60);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/cprd_pkg.sv
rtl/core/coherent_pulse_run_detector.sv
verif/cprd_run_checker.sv
verif/coherent_pulse_run_detector_test.sv
